>>> design/selective_repeat_receiver_assert.svh
// ----------------------------------------------------------------------------
// Selective-repeat receiver assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SRR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and defaults for the selective-repeat receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    localparam int unsigned SEQ_BITS_DEF = 16;
    localparam int unsigned WINDOW_DEF   = 64;

    localparam int unsigned SEQ_W   = 16;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_HELD      = 2'd1,
        ST_OLD       = 2'd2,
        ST_DROPPED   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } state_t;

    // control word into the held-map chain
    typedef struct packed {
        logic shift;   // every cell takes its right neighbor
        logic set_en;  // mark one cell held
    } srr_ctl_t;

endpackage

`default_nettype wire

>>> design/srr_cell.sv
// ----------------------------------------------------------------------------
// srr_cell
// One held-map bit: shifts in from its right neighbor or gets marked held.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire srr_pkg::srr_ctl_t ctl,
    input  wire logic             right_in,
    output logic                  held
);
    import srr_pkg::*;

    logic held_reg;
    logic held_next;

    always_comb
    begin
        held_next = held_reg;
        if (ctl.shift)
        begin
            held_next = right_in;
        end
        else if (ctl.set_en)
        begin
            held_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

`default_nettype wire

>>> design/srr_chain.sv
// ----------------------------------------------------------------------------
// srr_chain
// Row of held-map cells; cell i holds packet next_expected + i.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_chain #(
    parameter int unsigned WINDOW = srr_pkg::WINDOW_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire srr_pkg::srr_ctl_t           ctl,
    input  wire logic [$clog2(WINDOW)-1:0]  set_idx,
    output logic                            head
);
    import srr_pkg::*;

    localparam int unsigned IDXW = $clog2(WINDOW);

    logic [WINDOW-1:0] held;
    logic [WINDOW:0]   link;

    assign link[WINDOW] = 1'b0;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        srr_ctl_t cell_ctl;

        always_comb
        begin
            cell_ctl.shift  = ctl.shift;
            cell_ctl.set_en = ctl.set_en && (set_idx == IDXW'(i));
        end

        srr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .right_in (link[i+1]),
            .held     (held[i])
        );

        assign link[i] = held[i];
    end

    assign head = link[0];

endmodule

`default_nettype wire

>>> design/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective-repeat ARQ receiver with an out-of-order held map.
// ----------------------------------------------------------------------------
// Usage:
//   Packet channel: pkt_valid / pkt_stall carry one seq_num per beat. A beat
//   is taken when pkt_valid is high and pkt_stall low.
//   Result channel: res_valid / res_stall carry one result beat per packet
//   (ack_valid, ack_seq, deliver_count, deliver_first, status).
//   A held, old or dropped packet shows its result the cycle after it is
//   taken. An in-order packet that releases k packets walks the held map
//   one position per cycle and shows its result once the walk ends and the
//   result register is free; the walk length is set by the shifting cell chain.
//   Out of order, a new packet is taken whenever the result register can
//   take a beat; in order, new packets wait until its result is loaded.
//   The block works on one packet at a time; pkt_stall is high while a
//   walk runs or while the result register is full and stalled.
//   Reset: next expected number goes to zero and every held bit clears at
//   once; no clearing pass is needed.
//   When res_stall holds, the result beat stays put and new packets wait.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receiver #(
    parameter int unsigned SEQ_BITS = srr_pkg::SEQ_BITS_DEF,
    parameter int unsigned WINDOW   = srr_pkg::WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // packet channel
    input  wire logic                          pkt_valid,
    output logic                               pkt_stall,
    input  wire logic [srr_pkg::SEQ_W-1:0]     seq_num,
    // result channel
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic                               ack_valid,
    output logic [srr_pkg::SEQ_W-1:0]          ack_seq,
    output logic [srr_pkg::COUNT_W-1:0]        deliver_count,
    output logic [srr_pkg::SEQ_W-1:0]          deliver_first,
    output logic [1:0]                         status
);
    import srr_pkg::*;

    localparam int unsigned IDXW = $clog2(WINDOW);
    localparam int unsigned CW   = $clog2(WINDOW + 1);

    // control state
    state_t              state_reg,  state_next;
    logic [SEQ_BITS-1:0] ne_reg,     ne_next;     // next expected number
    logic [CW-1:0]       cnt_reg,    cnt_next;    // packets released so far
    logic                res_valid_reg, res_valid_next;

    // payload
    logic [SEQ_W-1:0]    first_reg,  first_next;  // in-order packet of the walk
    logic                ack_valid_reg,  ack_valid_next;
    logic [SEQ_W-1:0]    ack_seq_reg,    ack_seq_next;
    logic [COUNT_W-1:0]  deliver_count_reg, deliver_count_next;
    logic [SEQ_W-1:0]    deliver_first_reg, deliver_first_next;
    status_t             status_reg,     status_next;
    logic                load;

    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] gap;
    logic                in_win;
    logic                out_free;
    logic                head;
    srr_ctl_t            ctl;
    logic [IDXW-1:0]     set_idx;

    assign seq     = SEQ_BITS'(seq_num);
    assign gap     = seq - ne_reg;
    // ahead, in the front half of the sequence space and inside the window
    assign in_win  = !gap[SEQ_BITS-1] && (33'(gap) < 33'(WINDOW));
    assign set_idx = IDXW'(gap);
    // result register can take a beat this cycle
    assign out_free = !res_valid_reg || !res_stall;

    srr_chain #(
        .WINDOW (WINDOW)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .set_idx (set_idx),
        .head    (head)
    );

    always_comb
    begin
        state_next         = state_reg;
        ne_next            = ne_reg;
        cnt_next           = cnt_reg;
        first_next         = first_reg;
        res_valid_next     = res_valid_reg && res_stall;
        ack_valid_next     = ack_valid_reg;
        ack_seq_next       = ack_seq_reg;
        deliver_count_next = deliver_count_reg;
        deliver_first_next = deliver_first_reg;
        status_next        = status_reg;
        load               = 1'b0;
        ctl                = '0;
        pkt_stall          = (state_reg != S_IDLE) || !out_free;

        case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid && out_free)
                begin
                    if (gap == '0)
                    begin
                        // in order: release it, then walk the held run
                        ctl.shift  = 1'b1;
                        cnt_next   = CW'(1);
                        ne_next    = ne_reg + SEQ_BITS'(1);
                        first_next = SEQ_W'(seq);
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        load               = 1'b1;
                        res_valid_next     = 1'b1;
                        ctl.set_en         = in_win;
                        ack_valid_next     = in_win;
                        ack_seq_next       = in_win ? SEQ_W'(seq) : '0;
                        deliver_count_next = '0;
                        deliver_first_next = '0;
                        if (in_win)
                        begin
                            status_next = ST_HELD;
                        end
                        else if (gap[SEQ_BITS-1])
                        begin
                            status_next = ST_OLD;
                        end
                        else
                        begin
                            status_next = ST_DROPPED;
                        end
                    end
                end
            end

            S_DRAIN:
            begin
                if (head && (cnt_reg != CW'(WINDOW)))
                begin
                    // next packet was held: release it too
                    ctl.shift = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                    ne_next   = ne_reg + SEQ_BITS'(1);
                end
                else if (out_free)
                begin
                    load               = 1'b1;
                    res_valid_next     = 1'b1;
                    ack_valid_next     = 1'b1;
                    ack_seq_next       = first_reg;
                    deliver_count_next = COUNT_W'(cnt_reg);
                    deliver_first_next = first_reg;
                    status_next        = ST_DELIVERED;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ne_reg        <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        if (load)
        begin
            ack_valid_reg     <= ack_valid_next;
            ack_seq_reg       <= ack_seq_next;
            deliver_count_reg <= deliver_count_next;
            deliver_first_reg <= deliver_first_next;
            status_reg        <= status_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign ack_valid     = ack_valid_reg;
    assign ack_seq       = ack_seq_reg;
    assign deliver_count = deliver_count_reg;
    assign deliver_first = deliver_first_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

>>> design/srr_checker.sv
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks on the receiver's packet and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_receiver_assert.svh"

module srr_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pkt_valid,
    input  wire logic                       pkt_stall,
    input  wire logic [srr_pkg::SEQ_W-1:0]  seq_num,
    input  wire logic                       res_valid,
    input  wire logic                       res_stall,
    input  wire logic                       ack_valid,
    input  wire logic [srr_pkg::SEQ_W-1:0]  ack_seq,
    input  wire logic [srr_pkg::COUNT_W-1:0] deliver_count,
    input  wire logic [srr_pkg::SEQ_W-1:0]  deliver_first,
    input  wire logic [1:0]                 status
);
    import srr_pkg::*;

    // stalled result beat holds
    `SRR_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && res_stall,
        res_valid && $stable(ack_seq) && $stable(status) && $stable(deliver_count),
        "result beat changed while stalled")

    // acks only go out for delivered or held packets
    `SRR_ASSERT_IMP(a_ack_status, clk, rst_n, res_valid,
        ack_valid == (status == ST_DELIVERED || status == ST_HELD),
        "ack_valid does not match status")

    // ignored packets carry an all-zero payload
    `SRR_ASSERT_IMP(a_noack_zero, clk, rst_n, res_valid && !ack_valid,
        ack_seq == '0 && deliver_count == '0 && deliver_first == '0,
        "unacknowledged result has nonzero payload")

    // a delivery starts at the acknowledged packet
    `SRR_ASSERT_IMP(a_deliver_first, clk, rst_n, res_valid && status == ST_DELIVERED,
        deliver_first == ack_seq,
        "deliver_first differs from ack_seq")

    // stalled packet beat holds
    `SRR_ASSERT_NXT(a_pkt_hold, clk, rst_n, pkt_valid && pkt_stall,
        pkt_valid && $stable(seq_num),
        "packet beat changed while stalled")

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt_valid     (pkt_valid),
    .pkt_stall     (pkt_stall),
    .seq_num       (seq_num),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .ack_valid     (ack_valid),
    .ack_seq       (ack_seq),
    .deliver_count (deliver_count),
    .deliver_first (deliver_first),
    .status        (status)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver testbench
// Drives packet sequence numbers into the receiver and checks every result
// beat against a cycle-free model of the receive window (next expected
// number plus a bitmap of held packets). A short table of directed packets
// comes first, then random bursts: shuffled windows (some with a gap or a
// duplicate), full-window reversals, in-order runs and out-of-range noise.
// ----------------------------------------------------------------------------

module testbench;

    import srr_pkg::*;

    localparam int unsigned WIN          = WINDOW_DEF;
    localparam int unsigned RANDOM_BEATS = 1850;   // delivered or held packets to send

    // One result beat as the block presents it
    typedef struct packed {
        logic               ack;
        logic [SEQ_W-1:0]   ack_seq;
        logic [COUNT_W-1:0] count;
        logic [SEQ_W-1:0]   first_seq;
        status_t            st;
    } ack_beat_t;

    // Directed row: a packet and, where pinned, the beat it must produce
    typedef struct {
        logic [SEQ_W-1:0] seq;
        bit               pinned;
        ack_beat_t        beat;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                pkt_valid = 1'b0;
    logic [SEQ_W-1:0]    seq_num   = '0;
    logic                res_stall = 1'b0;
    logic                pkt_stall;
    logic                res_valid;
    logic                ack_valid;
    logic [SEQ_W-1:0]    ack_seq;
    logic [COUNT_W-1:0]  deliver_count;
    logic [SEQ_W-1:0]    deliver_first;
    logic [1:0]          status;

    // Window model: next in-order number and held bits relative to it
    logic [SEQ_W-1:0]    rx_next   = '0;
    logic [WIN-1:0]      held_bits = '0;

    ack_beat_t           ack_q[$];    // beats owed by the block, oldest first
    ack_beat_t           head_beat;

    int unsigned         snd_idle_pct  = 27;
    int unsigned         rcv_stall_pct = 78;
    int unsigned         fails         = 0;
    int unsigned         packets_sent  = 0;
    int unsigned         window_beats  = 0;   // delivered or held packets
    int unsigned         n_delivered   = 0;
    int unsigned         n_held        = 0;
    int unsigned         n_old         = 0;
    int unsigned         n_dropped     = 0;
    int unsigned         longest_run   = 0;

    always #5 clk = ~clk;

    selective_repeat_receiver #(
        .SEQ_BITS (SEQ_BITS_DEF),
        .WINDOW   (WIN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pkt_valid     (pkt_valid),
        .pkt_stall     (pkt_stall),
        .seq_num       (seq_num),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .ack_valid     (ack_valid),
        .ack_seq       (ack_seq),
        .deliver_count (deliver_count),
        .deliver_first (deliver_first),
        .status        (status)
    );

    // ------------------------------------------------------------------------
    // Window model. Advances the state for one arriving packet and returns
    // the beat the block owes for it.
    // ------------------------------------------------------------------------
    function automatic ack_beat_t predict_ack(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] gap;
        int unsigned      run;
        ack_beat_t        beat;
        beat = '0;
        gap  = seq - rx_next;
        if (gap == '0)
        begin
            // deliver this one plus the unbroken run of held packets after it
            run = 1;
            while (run < WIN && held_bits[run])
                run++;
            held_bits      = held_bits >> run;
            rx_next        = rx_next + SEQ_W'(run);
            beat.ack       = 1'b1;
            beat.ack_seq   = seq;
            beat.count     = COUNT_W'(run);
            beat.first_seq = seq;
            beat.st        = ST_DELIVERED;
        end
        else if (gap < WIN)
        begin
            // ahead but inside the window; re-arrival just re-acks
            held_bits[gap] = 1'b1;
            beat.ack       = 1'b1;
            beat.ack_seq   = seq;
            beat.st        = ST_HELD;
        end
        else if (gap[SEQ_W-1])
            beat.st = ST_OLD;       // back half of the number space
        else
            beat.st = ST_DROPPED;   // front half, past the window
        return beat;
    endfunction

    function automatic stim_row_t pinned_row(input logic [SEQ_W-1:0] seq,
                                             input logic ack,
                                             input logic [SEQ_W-1:0] aseq,
                                             input int unsigned cnt,
                                             input logic [SEQ_W-1:0] fseq,
                                             input status_t st);
        stim_row_t row;
        row.seq            = seq;
        row.pinned         = 1'b1;
        row.beat.ack       = ack;
        row.beat.ack_seq   = aseq;
        row.beat.count     = COUNT_W'(cnt);
        row.beat.first_seq = fseq;
        row.beat.st        = st;
        return row;
    endfunction

    function automatic stim_row_t open_row(input logic [SEQ_W-1:0] seq);
        stim_row_t row;
        row.seq    = seq;
        row.pinned = 1'b0;
        row.beat   = '0;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Packet driver. Called at a rising edge; returns at the edge where the
    // beat is taken, so a back-to-back caller just swaps the payload while
    // valid stays high. The model runs at acceptance, in packet order.
    // ------------------------------------------------------------------------
    task automatic send_packet(input logic [SEQ_W-1:0] seq,
                               input bit pinned,
                               input ack_beat_t pinned_beat);
        ack_beat_t predicted;
        if ($urandom_range(99) < snd_idle_pct)
        begin
            pkt_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct)
                @(posedge clk);
        end
        pkt_valid <= 1'b1;
        seq_num   <= seq;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        predicted = predict_ack(seq);
        ack_q.push_back(pinned ? pinned_beat : predicted);
        packets_sent++;
        if (predicted.st == ST_DELIVERED || predicted.st == ST_HELD)
            window_beats++;
    endtask

    // Hold off the sender until every owed beat has come back
    task automatic drain_results();
        pkt_valid <= 1'b0;
        do
            @(posedge clk);
        while (ack_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, field compare against the oldest owed beat.
    // Values read here are the ones settled before this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (ack_q.size() == 0)
            begin
                $error("result beat with nothing outstanding (ack_seq %0d, status %0d)",
                       ack_seq, status);
                fails++;
            end
            else
            begin
                head_beat = ack_q.pop_front();
                if (ack_valid !== head_beat.ack)
                begin
                    $error("ack_valid: expected %0d, got %0d", head_beat.ack, ack_valid);
                    fails++;
                end
                if (ack_seq !== head_beat.ack_seq)
                begin
                    $error("ack_seq: expected %0d, got %0d", head_beat.ack_seq, ack_seq);
                    fails++;
                end
                if (deliver_count !== head_beat.count)
                begin
                    $error("deliver_count: expected %0d, got %0d",
                           head_beat.count, deliver_count);
                    fails++;
                end
                if (deliver_first !== head_beat.first_seq)
                begin
                    $error("deliver_first: expected %0d, got %0d",
                           head_beat.first_seq, deliver_first);
                    fails++;
                end
                if (status !== head_beat.st)
                begin
                    $error("status: expected %s, got %0d", head_beat.st.name(), status);
                    fails++;
                end
                case (head_beat.st)
                    ST_DELIVERED:
                    begin
                        n_delivered++;
                        if (head_beat.count > longest_run)
                            longest_run = head_beat.count;
                    end
                    ST_HELD:    n_held++;
                    ST_OLD:     n_old++;
                    default:    n_dropped++;
                endcase
            end
        end
        res_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t        rows[$];
        int unsigned      order[$];
        int unsigned      n, kind, j, k, tmp, phase_now;
        int               i;
        logic [SEQ_W-1:0] base;

        // Directed rows. Window starts at 0 after reset.
        rows.push_back(pinned_row(16'h0000, 1'b1, 16'h0000, 1, 16'h0000, ST_DELIVERED));
        rows.push_back(pinned_row(16'h0000, 1'b0, 16'h0000, 0, 16'h0000, ST_OLD));
        // last slot of the window, then one past it
        rows.push_back(pinned_row(16'h0040, 1'b1, 16'h0040, 0, 16'h0000, ST_HELD));
        rows.push_back(pinned_row(16'h0041, 1'b0, 16'h0000, 0, 16'h0000, ST_DROPPED));
        // either side of the half-space boundary
        rows.push_back(pinned_row(16'h8000, 1'b0, 16'h0000, 0, 16'h0000, ST_DROPPED));
        rows.push_back(pinned_row(16'h8001, 1'b0, 16'h0000, 0, 16'h0000, ST_OLD));
        rows.push_back(pinned_row(16'hFFFF, 1'b0, 16'h0000, 0, 16'h0000, ST_OLD));
        // held twice: re-ack, map unchanged
        rows.push_back(pinned_row(16'h0003, 1'b1, 16'h0003, 0, 16'h0000, ST_HELD));
        rows.push_back(pinned_row(16'h0003, 1'b1, 16'h0003, 0, 16'h0000, ST_HELD));
        rows.push_back(open_row(16'h0002));
        rows.push_back(open_row(16'h0001));   // releases 1..3
        rows.push_back(open_row(16'h0004));
        rows.push_back(open_row(16'h7FFF));
        rows.push_back(open_row(16'hFFFE));
        rows.push_back(open_row(16'h0043));
        rows.push_back(open_row(16'h0006));
        rows.push_back(open_row(16'h0007));
        rows.push_back(open_row(16'h0005));   // releases 5..7
        rows.push_back(open_row(16'h0008));
        rows.push_back(open_row(16'h0400));
        rows.push_back(open_row(16'h5555));
        rows.push_back(open_row(16'hAAAA));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
            send_packet(rows[r].seq, rows[r].pinned, rows[r].beat);
        drain_results();

        // Random bursts, built from the window state at the start of each
        window_beats = 0;
        phase_now    = 0;
        while (window_beats < RANDOM_BEATS)
        begin
            // idling phases; pause for a full drain at each switch
            if (phase_now == 0 && window_beats >= RANDOM_BEATS / 3)
            begin
                drain_results();
                phase_now     = 1;
                snd_idle_pct  = 78;
                rcv_stall_pct = 27;
            end
            else if (phase_now == 1 && window_beats >= 2 * RANDOM_BEATS / 3)
            begin
                drain_results();
                phase_now     = 2;
                snd_idle_pct  = 0;
                rcv_stall_pct = 0;
            end

            base = rx_next;
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                // shuffled block of the window, now and then broken
                n = ($urandom_range(9) == 0) ? $urandom_range(WIN, 13) : $urandom_range(12, 2);
                order.delete();
                for (i = 0; i < int'(n); i++)
                    order.push_back(i);
                for (i = int'(n) - 1; i > 0; i--)
                begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                case ($urandom_range(7))
                    0: order.delete($urandom_range(n - 1));      // leave a gap
                    1:
                    begin
                        j = $urandom_range(n - 1);
                        k = $urandom_range(n - 1);
                        order.insert(j, order[k]);               // duplicate
                    end
                    default: ;
                endcase
                foreach (order[m])
                    send_packet(base + SEQ_W'(order[m]), 1'b0, '0);
            end
            else if (kind < 49)
            begin
                // fill the whole window backwards, then release it in one go
                for (i = WIN - 1; i >= 0; i--)
                    send_packet(base + SEQ_W'(i), 1'b0, '0);
            end
            else if (kind < 75)
            begin
                n = $urandom_range(16, 1);
                for (i = 0; i < int'(n); i++)
                    send_packet(base + SEQ_W'(i), 1'b0, '0);
            end
            else
            begin
                case ($urandom_range(2))
                    0: send_packet(SEQ_W'($urandom), 1'b0, '0);
                    1: send_packet(base - SEQ_W'($urandom_range(32768, 1)), 1'b0, '0);
                    default: send_packet(base + SEQ_W'($urandom_range(32767, WIN)),
                                         1'b0, '0);
                endcase
            end
        end

        // Wait out every owed beat, then keep the clock running so that a stray
        // extra beat would still be caught.
        drain_results();
        repeat (WIN + 16) @(posedge clk);

        $display("%0d packets sent; beats: %0d delivered (longest release %0d), %0d held",
                 packets_sent, n_delivered, longest_run, n_held);
        $display("  %0d old or duplicate, %0d beyond the window", n_old, n_dropped);
        if (fails == 0)
            $display("selective_repeat_receiver regression: pass");
        else
            $display("selective_repeat_receiver regression: fail");
        $finish;
    end

    // Hard stop well past the slowest legitimate run
    initial
    begin
        #10_000_000;
        $display("selective_repeat_receiver regression: fail");
        $finish;
    end

endmodule
